// ===== rtl/csvcs_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV cell splitter package
// Shared payload types, character codes and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csvcs_pkg;

    // Default limits for the top-level parameters.
    localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd65536;
    localparam longint unsigned MAX_ROWS_DEF       = 64'd65536;
    localparam longint unsigned MAX_COLUMNS_DEF    = 64'd4096;

    // Character codes with structural meaning.
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Result kinds.
    localparam logic KIND_CELL    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue sizing.
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] cell_row;
        logic [11:0] cell_column;
        logic [15:0] cell_start;
        logic [15:0] cell_length;
        logic [16:0] total_rows;
        logic [12:0] total_columns;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        logic             not_empty;
        logic             room;
        logic [CNT_W-1:0] fill;
    } q_status_t;

    function automatic logic [11:0] clamp12(logic [63:0] v);
        return (v > 64'hFFF) ? 12'hFFF : v[11:0];
    endfunction

    function automatic logic [12:0] clamp13(logic [63:0] v);
        return (v > 64'h1FFF) ? 13'h1FFF : v[12:0];
    endfunction

    function automatic logic [15:0] clamp16(logic [63:0] v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [16:0] clamp17(logic [63:0] v);
        return (v > 64'h1FFFF) ? 17'h1FFFF : v[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/csv_cell_splitter_core.sv =====
// ----------------------------------------------------------------------------
// CSV cell splitter
// Splits a CSV byte stream into cell records and a closing document summary.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the result queue holds at most one
// result, and its results are ready from the next cycle on. Bytes that close
// no cell or close one cell sustain one byte per cycle; the final byte of a
// document yields up to three results (separator cell, flushed cell,
// summary), which leave the four-entry result queue one per cycle, so input
// pauses until the queue holds at most one result again. Output back-pressure stalls input
// once the queue holds two or more results.
`default_nettype none

module csv_cell_splitter_core #(
    parameter longint unsigned MAX_TEXT_BYTES = csvcs_pkg::MAX_TEXT_BYTES_DEF,
    parameter longint unsigned MAX_ROWS       = csvcs_pkg::MAX_ROWS_DEF,
    parameter longint unsigned MAX_COLUMNS    = csvcs_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire csvcs_pkg::in_t  s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output csvcs_pkg::out_t      m_payload
);

    logic                      accept;
    logic                      pop;
    logic [1:0]                push_count;
    csvcs_pkg::out_t [2:0]     push_data;
    csvcs_pkg::q_status_t      q_status;

    assign s_ready = q_status.room;
    assign accept  = s_valid && s_ready;
    assign m_valid = q_status.not_empty;
    assign pop     = m_valid && m_ready;

    csvcs_parse #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .MAX_ROWS       (MAX_ROWS),
        .MAX_COLUMNS    (MAX_COLUMNS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .item       (s_payload),
        .push_count (push_count),
        .push_data  (push_data)
    );

    csvcs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data  (push_data),
        .pop        (pop),
        .head       (m_payload),
        .status     (q_status)
    );

    // The queue never holds more results than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.fill <= csvcs_pkg::CNT_W'(csvcs_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // Results disappear only when they were taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without a transaction");

    // A summary always closes the run of results for its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.result_kind == csvcs_pkg::KIND_SUMMARY)
            |-> m_payload.last_of_run)
        else $error("summary not marked as last of run");

    // Nothing is pushed without an accepted byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> q_status.fill <= $past(q_status.fill))
        else $error("queue grew without an input transaction");

endmodule

`default_nettype wire

// ===== rtl/csvcs_parse.sv =====
// ----------------------------------------------------------------------------
// CSV cell splitter parse stage
// Holds the quoting and cell tracking state and turns one accepted byte into
// up to three results in the cycle it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module csvcs_parse #(
    parameter longint unsigned MAX_TEXT_BYTES = csvcs_pkg::MAX_TEXT_BYTES_DEF,
    parameter longint unsigned MAX_ROWS       = csvcs_pkg::MAX_ROWS_DEF,
    parameter longint unsigned MAX_COLUMNS    = csvcs_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire csvcs_pkg::in_t        item,
    output logic [1:0]                 push_count,
    output csvcs_pkg::out_t [2:0]      push_data
);

    localparam int OFS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);

    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_TEXT_BYTES);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_COLUMNS);

    typedef struct packed {
        logic [OFS_W-1:0] cell_begin;
        logic [OFS_W-1:0] lead_nl;
        logic             only_nl;
        logic             first_quote;
        logic             last_quote;
    } trk_t;

    function automatic trk_t trk_init(logic [OFS_W-1:0] pos);
        trk_t t;
        t.cell_begin  = pos;
        t.lead_nl     = '0;
        t.only_nl     = 1'b1;
        t.first_quote = 1'b0;
        t.last_quote  = 1'b0;
        return t;
    endfunction

    function automatic trk_t trk_step(trk_t t_in, logic [7:0] b);
        trk_t t;
        t = t_in;
        if (t.only_nl) begin
            if (b == csvcs_pkg::CHAR_LF) begin
                t.lead_nl = (t.lead_nl >= OFS_MAX) ? OFS_MAX : t.lead_nl + OFS_W'(1);
            end else begin
                t.only_nl     = 1'b0;
                t.first_quote = (b == csvcs_pkg::CHAR_QUOTE);
            end
        end
        t.last_quote = (b == csvcs_pkg::CHAR_QUOTE);
        return t;
    endfunction

    // Cell record for text ending just before end_pos, with leading
    // newlines trimmed and enclosing quotes stripped.
    function automatic csvcs_pkg::out_t cell_record(trk_t t, logic [OFS_W-1:0] end_pos,
                                                    logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] col,
                                                    logic last);
        csvcs_pkg::out_t r;
        logic [OFS_W-1:0] raw;
        logic [OFS_W-1:0] len;
        logic [OFS_W:0]   start;
        raw   = (end_pos > t.cell_begin) ? end_pos - t.cell_begin : '0;
        start = {1'b0, t.cell_begin} + {1'b0, t.lead_nl};
        len   = (raw > t.lead_nl) ? raw - t.lead_nl : '0;
        if (t.only_nl) begin
            len = '0;
        end else if (t.first_quote && t.last_quote) begin
            start = start + (OFS_W + 1)'(1);
            len   = (len >= OFS_W'(2)) ? len - OFS_W'(2) : '0;
        end
        r               = '0;
        r.result_kind   = csvcs_pkg::KIND_CELL;
        r.cell_row      = csvcs_pkg::clamp16(64'(row));
        r.cell_column   = csvcs_pkg::clamp12(64'(col));
        r.cell_start    = csvcs_pkg::clamp16(64'(start));
        r.cell_length   = csvcs_pkg::clamp16(64'(len));
        r.last_of_run   = last;
        return r;
    endfunction

    logic [OFS_W-1:0] offset_reg, offset_next;
    trk_t             trk_reg, trk_next;
    logic             in_quotes_reg, in_quotes_next;
    logic             quote_pending_reg, quote_pending_next;
    logic             field_seen_reg, field_seen_next;
    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] widest_row_reg, widest_row_next;

    logic [7:0]       b;
    logic             eot;
    logic [OFS_W-1:0] pos_after;
    trk_t             trk;
    logic             iq;
    logic             qp;
    logic             fs;
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] rc;
    logic [COL_W-1:0] wr;
    logic             handled;
    logic             sep_valid;
    logic             flush_valid;
    csvcs_pkg::out_t  sep_res;
    csvcs_pkg::out_t  flush_res;
    csvcs_pkg::out_t  sum_res;

    always_comb begin
        b           = item.data_byte;
        eot         = item.end_of_text;
        pos_after   = (offset_reg >= OFS_MAX) ? OFS_MAX : offset_reg + OFS_W'(1);
        trk         = trk_reg;
        iq          = in_quotes_reg;
        qp          = quote_pending_reg;
        fs          = field_seen_reg;
        cc          = column_count_reg;
        rc          = row_count_reg;
        wr          = widest_row_reg;
        handled     = 1'b0;
        sep_valid   = 1'b0;
        flush_valid = 1'b0;
        sep_res     = '0;
        flush_res   = '0;
        sum_res     = '0;

        // A quote seen inside quotes waits for this byte: a second quote
        // makes the pair plain text, anything else closes the quoted part.
        if (qp) begin
            qp = 1'b0;
            if (b == csvcs_pkg::CHAR_QUOTE) begin
                trk     = trk_step(trk, b);
                handled = 1'b1;
            end else begin
                iq = 1'b0;
                fs = 1'b1;
            end
        end

        if (!handled) begin
            if (b == csvcs_pkg::CHAR_QUOTE) begin
                if (iq) begin
                    if (eot) begin
                        iq = 1'b0;
                        fs = 1'b1;
                    end else begin
                        qp = 1'b1;
                    end
                end else begin
                    iq = 1'b1;
                    fs = 1'b1;
                end
                trk = trk_step(trk, b);
            end else if (!iq && b == csvcs_pkg::CHAR_COMMA) begin
                sep_valid = 1'b1;
                sep_res   = cell_record(trk, offset_reg, rc, cc, !eot);
                cc        = (cc >= COL_MAX) ? COL_MAX : cc + COL_W'(1);
                fs        = 1'b0;
                trk       = trk_init(pos_after);
            end else if (!iq && b == csvcs_pkg::CHAR_LF) begin
                if (fs || cc != '0) begin
                    sep_valid = 1'b1;
                    sep_res   = cell_record(trk, offset_reg, rc, cc, !eot);
                    cc        = (cc >= COL_MAX) ? COL_MAX : cc + COL_W'(1);
                    trk       = trk_init(pos_after);
                end else begin
                    trk = trk_step(trk, b);
                end
                rc = (rc >= ROW_MAX) ? ROW_MAX : rc + ROW_W'(1);
                if (cc > wr) begin
                    wr = cc;
                end
                cc = '0;
                fs = 1'b0;
            end else begin
                if (iq || b != csvcs_pkg::CHAR_CR) begin
                    fs = 1'b1;
                end
                trk = trk_step(trk, b);
            end
        end

        if (eot) begin
            if (fs || cc != '0) begin
                flush_valid = 1'b1;
                flush_res   = cell_record(trk, pos_after, rc, cc, 1'b0);
                cc          = (cc >= COL_MAX) ? COL_MAX : cc + COL_W'(1);
                rc          = (rc >= ROW_MAX) ? ROW_MAX : rc + ROW_W'(1);
                if (cc > wr) begin
                    wr = cc;
                end
            end
            sum_res.result_kind   = csvcs_pkg::KIND_SUMMARY;
            sum_res.total_columns = csvcs_pkg::clamp13(64'(wr));
            sum_res.total_rows    = (wr != '0) ? csvcs_pkg::clamp17(64'(rc)) : '0;
            sum_res.last_of_run   = 1'b1;
        end

        // A finished document returns everything to the reset state.
        if (eot) begin
            offset_next        = '0;
            trk_next           = trk_init('0);
            in_quotes_next     = 1'b0;
            quote_pending_next = 1'b0;
            field_seen_next    = 1'b0;
            column_count_next  = '0;
            row_count_next     = '0;
            widest_row_next    = '0;
        end else begin
            offset_next        = pos_after;
            trk_next           = trk;
            in_quotes_next     = iq;
            quote_pending_next = qp;
            field_seen_next    = fs;
            column_count_next  = cc;
            row_count_next     = rc;
            widest_row_next    = wr;
        end

        // Pack the results in order: separator cell, flushed cell, summary.
        push_data[0] = sep_valid ? sep_res : (flush_valid ? flush_res : sum_res);
        push_data[1] = sep_valid ? (flush_valid ? flush_res : sum_res) : sum_res;
        push_data[2] = sum_res;
        push_count   = accept ? (2'(sep_valid) + 2'(flush_valid) + 2'(eot)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg        <= '0;
            trk_reg           <= trk_init('0);
            in_quotes_reg     <= 1'b0;
            quote_pending_reg <= 1'b0;
            field_seen_reg    <= 1'b0;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            widest_row_reg    <= '0;
        end else if (accept) begin
            offset_reg        <= offset_next;
            trk_reg           <= trk_next;
            in_quotes_reg     <= in_quotes_next;
            quote_pending_reg <= quote_pending_next;
            field_seen_reg    <= field_seen_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            widest_row_reg    <= widest_row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csvcs_fifo.sv =====
// ----------------------------------------------------------------------------
// CSV cell splitter result queue
// Small queue that takes up to three results per cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module csvcs_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [1:0]             push_count,
    input  wire csvcs_pkg::out_t [2:0]  push_data,
    input  wire logic                   pop,
    output csvcs_pkg::out_t             head,
    output csvcs_pkg::q_status_t        status
);

    localparam int DEPTH = csvcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = csvcs_pkg::PTR_W;
    localparam int CNT_W = csvcs_pkg::CNT_W;

    csvcs_pkg::out_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < csvcs_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push_count) begin
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head             = mem[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    // Room is judged without the current pop so that ready stays registered-only.
    assign status.room      = (count_reg <= CNT_W'(DEPTH - csvcs_pkg::MAX_RESULTS));
    assign status.fill      = count_reg;

endmodule

`default_nettype wire
